// File: rtl/pci_pkg.sv
// shared constants, codes and control structs of the partition cell individualizer
package pci_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_CELLS_DEF    = 128;

   // operation codes
   localparam logic [2:0] OP_SET   = 3'd0;
   localparam logic [2:0] OP_ADD   = 3'd1;
   localparam logic [2:0] OP_INDIV = 3'd2;
   localparam logic [2:0] OP_QUERY = 3'd3;
   localparam logic [2:0] OP_REP   = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_UNIT  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // datapath phase commands
   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_READ  = 4'd1;
   localparam logic [3:0] PH_SZRD  = 4'd2;
   localparam logic [3:0] PH_EXEC  = 4'd3;
   localparam logic [3:0] PH_NEWSZ = 4'd4;
   localparam logic [3:0] PH_RR_V  = 4'd5;
   localparam logic [3:0] PH_RR_U  = 4'd6;
   localparam logic [3:0] PH_RR_W  = 4'd7;
   localparam logic [3:0] PH_SCAN  = 4'd8;
   localparam logic [3:0] PH_DONE  = 4'd9;

   typedef struct packed {
      logic       capture;
      logic [3:0] phase;
   } cmd_type;

   typedef struct packed {
      logic go_ind;
      logic go_scan;
      logic scan_done;
      logic rr_done;
      logic rr_placed;
      logic out_free;
   } sts_type;

endpackage

// File: rtl/pci_ctrl.sv
// controller state machine sequencing the partition datapath
module pci_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pci_pkg::sts_type sts,
   output pci_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD   = 4'd1;
   localparam logic [3:0] S_SZ   = 4'd2;
   localparam logic [3:0] S_EX   = 4'd3;
   localparam logic [3:0] S_NS   = 4'd4;
   localparam logic [3:0] S_RRV  = 4'd5;
   localparam logic [3:0] S_RRU  = 4'd6;
   localparam logic [3:0] S_RRW  = 4'd7;
   localparam logic [3:0] S_SCAN = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.phase   = pci_pkg::PH_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = S_RD;
         end
         S_RD: begin
            cmd.phase = pci_pkg::PH_READ;
            state_in  = S_SZ;
         end
         S_SZ: begin
            cmd.phase = pci_pkg::PH_SZRD;
            state_in  = S_EX;
         end
         S_EX: begin
            cmd.phase = pci_pkg::PH_EXEC;
            if (sts.go_ind) state_in = S_NS;
            else if (sts.go_scan) state_in = S_SCAN;
            else state_in = S_DONE;
         end
         S_NS: begin
            cmd.phase = pci_pkg::PH_NEWSZ;
            state_in  = S_RRV;
         end
         S_RRV: begin
            cmd.phase = pci_pkg::PH_RR_V;
            if (sts.rr_done) state_in = S_DONE;
            else if (sts.rr_placed) state_in = S_RRU;
         end
         S_RRU: begin
            cmd.phase = pci_pkg::PH_RR_U;
            if (sts.scan_done) state_in = S_RRW;
         end
         S_RRW: begin
            cmd.phase = pci_pkg::PH_RR_W;
            state_in  = S_RRV;
         end
         S_SCAN: begin
            cmd.phase = pci_pkg::PH_SCAN;
            if (sts.scan_done) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.phase = pci_pkg::PH_DONE;
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_RD))
      else $error("accepted request did not start a read");
`endif

endmodule

// File: rtl/pci_datapath.sv
// partition tables, scan engine, counters and result register
module pci_datapath #(
   parameter int MAX_VERTICES = pci_pkg::MAX_VERTICES_DEF,
   parameter int MAX_CELLS    = pci_pkg::MAX_CELLS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  pci_pkg::cmd_type cmd,
   output pci_pkg::sts_type sts,
   input  logic [2:0]       req_operation,
   input  logic [5:0]       req_vertex,
   input  logic [6:0]       req_cell_req,
   input  logic [15:0]      req_color,
   input  logic [15:0]      req_degree,
   input  logic             csr_valid,
   input  logic [6:0]       csr_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [6:0]       rsp_found_cell,
   output logic [5:0]       rsp_position,
   output logic [5:0]       rsp_representative,
   output logic             rsp_is_discrete,
   output logic [7:0]       rsp_single_count,
   output logic [7:0]       rsp_cell_count
);

   localparam int VW     = $clog2(MAX_VERTICES);
   localparam int CW     = $clog2(MAX_CELLS);
   localparam int SZW    = $clog2(MAX_VERTICES + 1);
   localparam int CNTW   = $clog2(MAX_CELLS + 1);
   localparam int NV_RST = (64 > MAX_VERTICES) ? MAX_VERTICES : 64;
   localparam logic [VW:0] U_END = (VW + 1)'(MAX_VERTICES);

   // request fields
   logic [2:0]  op_ff;
   logic [5:0]  v_ff;
   logic [6:0]  c_ff;
   logic [31:0] attr_req_ff;

   logic [6:0]              num_vert_ff;
   logic [MAX_VERTICES-1:0] placed_ff;
   logic [MAX_VERTICES-1:0] attr_vld_ff;
   logic [MAX_CELLS-1:0]    size_vld_ff;
   logic [CNTW-1:0]         cells_used_ff;
   logic [CNTW-1:0]         single_ff;

   // tables
   logic [CW-1:0]  cell_mem [MAX_VERTICES];
   logic [31:0]    attr_mem [MAX_VERTICES];
   logic [VW-1:0]  pos_mem  [MAX_VERTICES];
   logic [SZW-1:0] size_mem [MAX_CELLS];

   logic [CW-1:0]  cell_a_q, cell_b_q;
   logic [31:0]    attr_a_q, attr_b_q;
   logic           attr_vld_a_q, attr_vld_b_q;
   logic [VW-1:0]  pos_q;
   logic [SZW-1:0] size_q;
   logic           size_vld_q;

   // scan engine
   logic [VW:0]    u_ff, rv_ff;
   logic [VW-1:0]  pidx_ff, best_ff, rank_ff;
   logic [31:0]    best_attr_ff;
   logic           pend_ff, any_ff;
   logic [CW-1:0]  nc_ff;

   // held result
   logic [1:0] res_status_ff;
   logic [6:0] res_found_ff;
   logic [5:0] res_pos_ff;

   logic [1:0] rsp_status_ff;
   logic [6:0] rsp_found_ff;
   logic [5:0] rsp_pos_ff, rsp_rep_ff;
   logic       rsp_disc_ff, rsp_valid_ff;
   logic [7:0] rsp_dcnt_ff, rsp_ccnt_ff;

   logic [VW-1:0]  vi, rv_idx, addr_a;
   logic [CW-1:0]  ci, size_addr;
   logic           vok, cok, placed_v;
   logic [SZW-1:0] size_eff;
   logic [31:0]    attr_a, attr_b;
   logic           scan_ph, scan_issue, member, rank_hit, rep_better, rd_a, load_out;
   logic           set_ok, add_ok, ind_ok, rep_go;
   logic [1:0]     ex_status;
   logic [6:0]     ex_found;
   logic [5:0]     ex_pos;
   logic           we_pos, we_size;
   logic [VW-1:0]  pos_wa, pos_wd;
   logic [CW-1:0]  size_wa, cell_wd;
   logic [SZW-1:0] size_wd;

   assign vi       = VW'(v_ff);
   assign ci       = CW'(c_ff);
   assign rv_idx   = rv_ff[VW-1:0];
   assign vok      = (32'(v_ff) < 32'(num_vert_ff)) && (32'(v_ff) < MAX_VERTICES);
   assign cok      = 32'(c_ff) < MAX_CELLS;
   assign placed_v = placed_ff[vi];
   assign size_eff = size_vld_q ? size_q : '0;
   assign attr_a   = attr_vld_a_q ? attr_a_q : '0;
   assign attr_b   = attr_vld_b_q ? attr_b_q : '0;

   assign scan_ph    = (cmd.phase == pci_pkg::PH_SCAN) || (cmd.phase == pci_pkg::PH_RR_U);
   assign scan_issue = scan_ph && (u_ff != U_END);
   assign member     = pend_ff && placed_ff[pidx_ff]
                       && (cell_b_q == ((cmd.phase == pci_pkg::PH_SCAN) ? ci : cell_a_q));
   // later index never wins a tie, so only color and degree decide
   assign rep_better = !any_ff || (attr_b < best_attr_ff);
   assign rank_hit   = member && ({attr_b, pidx_ff} < {attr_a, rv_idx});

   assign rd_a   = (cmd.phase == pci_pkg::PH_READ)
                   || ((cmd.phase == pci_pkg::PH_RR_V) && (rv_ff != U_END) && placed_ff[rv_idx]);
   assign addr_a = (cmd.phase == pci_pkg::PH_READ) ? vi : rv_idx;
   assign size_addr = (op_ff == pci_pkg::OP_INDIV) ? cell_a_q : ci;
   assign load_out  = (cmd.phase == pci_pkg::PH_DONE) && (!rsp_valid_ff || rsp_ready);

   // decision for the request
   always_comb begin
      set_ok    = 1'b0;
      add_ok    = 1'b0;
      ind_ok    = 1'b0;
      rep_go    = 1'b0;
      ex_status = pci_pkg::ST_OK;
      ex_found  = '0;
      ex_pos    = '0;
      case (op_ff)
         pci_pkg::OP_SET: begin
            if (!vok) ex_status = pci_pkg::ST_RANGE;
            else set_ok = 1'b1;
         end
         pci_pkg::OP_ADD: begin
            if (!vok || !cok) ex_status = pci_pkg::ST_RANGE;
            else if (placed_v) ex_status = pci_pkg::ST_UNIT;
            else add_ok = 1'b1;
         end
         pci_pkg::OP_INDIV: begin
            if (!vok) ex_status = pci_pkg::ST_RANGE;
            else if (!placed_v) ex_status = pci_pkg::ST_EMPTY;
            else if (size_eff == SZW'(1)) ex_status = pci_pkg::ST_UNIT;
            else if (32'(cells_used_ff) >= MAX_CELLS) ex_status = pci_pkg::ST_RANGE;
            else begin
               ind_ok   = 1'b1;
               ex_found = 7'(cells_used_ff);
            end
         end
         pci_pkg::OP_QUERY: begin
            if (!vok) ex_status = pci_pkg::ST_RANGE;
            else if (!placed_v) ex_status = pci_pkg::ST_EMPTY;
            else begin
               ex_found = 7'(cell_a_q);
               ex_pos   = 6'(pos_q);
            end
         end
         pci_pkg::OP_REP: begin
            if (!cok) ex_status = pci_pkg::ST_RANGE;
            else rep_go = 1'b1;
         end
         default: ex_status = pci_pkg::ST_RANGE;
      endcase
   end

   always_comb begin
      we_pos  = 1'b0;
      pos_wa  = vi;
      pos_wd  = '0;
      we_size = 1'b0;
      size_wa = ci;
      size_wd = '0;
      cell_wd = ind_ok ? CW'(cells_used_ff) : ci;
      if (cmd.phase == pci_pkg::PH_EXEC && add_ok) begin
         we_pos  = 1'b1;
         pos_wd  = VW'(size_eff);
         we_size = 1'b1;
         size_wd = size_eff + SZW'(1);
      end else if (cmd.phase == pci_pkg::PH_EXEC && ind_ok) begin
         we_pos  = 1'b1;
         we_size = 1'b1;
         size_wa = cell_a_q;
         size_wd = size_eff - SZW'(1);
      end else if (cmd.phase == pci_pkg::PH_NEWSZ) begin
         we_size = 1'b1;
         size_wa = nc_ff;
         size_wd = SZW'(1);
      end else if (cmd.phase == pci_pkg::PH_RR_W) begin
         we_pos = 1'b1;
         pos_wa = rv_idx;
         pos_wd = rank_ff;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.phase == pci_pkg::PH_EXEC && (add_ok || ind_ok)) cell_mem[vi] <= cell_wd;
      if (rd_a) cell_a_q <= cell_mem[addr_a];
      if (scan_issue) cell_b_q <= cell_mem[u_ff[VW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.phase == pci_pkg::PH_EXEC && set_ok) attr_mem[vi] <= attr_req_ff;
      if (rd_a) attr_a_q <= attr_mem[addr_a];
      if (scan_issue) attr_b_q <= attr_mem[u_ff[VW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (we_pos) pos_mem[pos_wa] <= pos_wd;
      if (cmd.phase == pci_pkg::PH_READ) pos_q <= pos_mem[vi];
   end

   always_ff @(posedge clock) begin
      if (we_size) size_mem[size_wa] <= size_wd;
      if (cmd.phase == pci_pkg::PH_SZRD) size_q <= size_mem[size_addr];
   end

   // valid bits travel with the registered read data
   always_ff @(posedge clock) begin
      if (rd_a) attr_vld_a_q <= attr_vld_ff[addr_a];
      if (scan_issue) attr_vld_b_q <= attr_vld_ff[u_ff[VW-1:0]];
      if (cmd.phase == pci_pkg::PH_SZRD) size_vld_q <= size_vld_ff[size_addr];
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_operation;
         v_ff        <= req_vertex;
         c_ff        <= req_cell_req;
         attr_req_ff <= {req_color, req_degree};
      end
      if (cmd.phase == pci_pkg::PH_EXEC) begin
         res_status_ff <= ex_status;
         res_found_ff  <= ex_found;
         res_pos_ff    <= ex_pos;
         nc_ff         <= CW'(cells_used_ff);
         u_ff          <= '0;
         any_ff        <= 1'b0;
      end
      if (cmd.phase == pci_pkg::PH_NEWSZ) rv_ff <= '0;
      if (cmd.phase == pci_pkg::PH_RR_V && rv_ff != U_END) begin
         if (placed_ff[rv_idx]) begin
            u_ff    <= '0;
            rank_ff <= '0;
         end else begin
            rv_ff <= rv_ff + 1'b1;
         end
      end
      if (cmd.phase == pci_pkg::PH_RR_W) rv_ff <= rv_ff + 1'b1;
      if (scan_issue) begin
         u_ff    <= u_ff + 1'b1;
         pidx_ff <= u_ff[VW-1:0];
      end
      if (cmd.phase == pci_pkg::PH_SCAN && member && rep_better) begin
         any_ff       <= 1'b1;
         best_ff      <= pidx_ff;
         best_attr_ff <= attr_b;
      end
      if (cmd.phase == pci_pkg::PH_RR_U && rank_hit) rank_ff <= rank_ff + 1'b1;
      if (load_out) begin
         if (op_ff == pci_pkg::OP_REP && cok) begin
            rsp_status_ff <= any_ff ? pci_pkg::ST_OK : pci_pkg::ST_EMPTY;
            rsp_rep_ff    <= any_ff ? 6'(best_ff) : '0;
         end else begin
            rsp_status_ff <= res_status_ff;
            rsp_rep_ff    <= '0;
         end
         rsp_found_ff <= res_found_ff;
         rsp_pos_ff   <= res_pos_ff;
         rsp_disc_ff  <= (32'(single_ff) == 32'(num_vert_ff));
         rsp_dcnt_ff  <= 8'(single_ff);
         rsp_ccnt_ff  <= 8'(cells_used_ff);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         num_vert_ff   <= 7'(NV_RST);
         placed_ff     <= '0;
         attr_vld_ff   <= '0;
         size_vld_ff   <= '0;
         cells_used_ff <= '0;
         single_ff     <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_data == 7'd0) num_vert_ff <= 7'd1;
            else if (32'(csr_data) > MAX_VERTICES) num_vert_ff <= 7'(MAX_VERTICES);
            else num_vert_ff <= csr_data;
         end
         if (cmd.phase == pci_pkg::PH_EXEC) begin
            pend_ff <= 1'b0;
            if (set_ok) attr_vld_ff[vi] <= 1'b1;
            if (add_ok) begin
               placed_ff[vi]   <= 1'b1;
               size_vld_ff[ci] <= 1'b1;
               if (size_eff == '0) single_ff <= single_ff + 1'b1;
               else if (size_eff == SZW'(1)) single_ff <= single_ff - 1'b1;
               if (32'(cells_used_ff) < 32'(c_ff) + 32'd1) begin
                  cells_used_ff <= CNTW'(32'(c_ff) + 32'd1);
               end
            end
            if (ind_ok) begin
               // old cell left with one member turns into a singleton too
               single_ff     <= single_ff + ((size_eff == SZW'(2)) ? CNTW'(2) : CNTW'(1));
               cells_used_ff <= cells_used_ff + 1'b1;
            end
         end
         if (cmd.phase == pci_pkg::PH_NEWSZ) size_vld_ff[nc_ff] <= 1'b1;
         if (cmd.phase == pci_pkg::PH_RR_V) pend_ff <= 1'b0;
         if (scan_ph) pend_ff <= scan_issue;
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.go_ind    = ind_ok;
   assign sts.go_scan   = rep_go;
   assign sts.scan_done = (u_ff == U_END) && !pend_ff;
   assign sts.rr_done   = (rv_ff == U_END);
   assign sts.rr_placed = placed_ff[rv_idx];
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_cell     = rsp_found_ff;
   assign rsp_position       = rsp_pos_ff;
   assign rsp_representative = rsp_rep_ff;
   assign rsp_is_discrete    = rsp_disc_ff;
   assign rsp_single_count   = rsp_dcnt_ff;
   assign rsp_cell_count     = rsp_ccnt_ff;

`ifndef SYNTHESIS
   a_single_le_cells: assert property (@(posedge clock) disable iff (reset)
      single_ff <= cells_used_ff)
      else $error("more singleton cells than cells in use");
   a_cells_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cells_used_ff) <= MAX_CELLS)
      else $error("cell count beyond table size");
   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> scan_ph)
      else $error("scan read pending outside a scan");
`endif

endmodule

// File: rtl/partition_cell_individualizer.sv
// top level of the ordered partition store with vertex individualization
//
//  channel  direction  signals
//  req      in         req_valid/req_ready, operation vertex cell_req color degree
//  rsp      out        rsp_valid/rsp_ready, status found_cell position representative
//                      is_discrete single_count cell_count
//  csr      in         csr_valid/csr_ready, csr_data = vertex limit
//
//  set, add and query pass the read, size read and execute states to reach the result
//  register; representative adds a scan over every vertex slot, and individualize a
//  rank scan for every placed vertex, all of it bound by the single pair of read
//  ports on the vertex cell and attribute tables. one request is worked at a time;
//  the next is taken once a result sits in the output register. synchronous reset
//  clears counters, placed bits and table valid bits at once; no clearing pass. csr
//  writes are always taken.
module partition_cell_individualizer #(
   parameter int MAX_VERTICES = pci_pkg::MAX_VERTICES_DEF,
   parameter int MAX_CELLS    = pci_pkg::MAX_CELLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [5:0]  req_vertex,
   input  logic [6:0]  req_cell_req,
   input  logic [15:0] req_color,
   input  logic [15:0] req_degree,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_found_cell,
   output logic [5:0]  rsp_position,
   output logic [5:0]  rsp_representative,
   output logic        rsp_is_discrete,
   output logic [7:0]  rsp_single_count,
   output logic [7:0]  rsp_cell_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);

   pci_pkg::cmd_type cmd;
   pci_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   pci_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pci_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_CELLS    (MAX_CELLS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_operation      (req_operation),
      .req_vertex         (req_vertex),
      .req_cell_req       (req_cell_req),
      .req_color          (req_color),
      .req_degree         (req_degree),
      .csr_valid          (csr_valid),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found_cell     (rsp_found_cell),
      .rsp_position       (rsp_position),
      .rsp_representative (rsp_representative),
      .rsp_is_discrete    (rsp_is_discrete),
      .rsp_single_count   (rsp_single_count),
      .rsp_cell_count     (rsp_cell_count)
   );

endmodule
